// File: rtl/core/indexed_random_set_queue_defines.svh
// ----------------------------------------------------------------------------
// indexed random set queue assertion macros
// shared property wrappers for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef INDEXED_RANDOM_SET_QUEUE_DEFINES_SVH
`define INDEXED_RANDOM_SET_QUEUE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define IRSQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("irsq same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define IRSQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("irsq next-cycle check failed");

`endif

// File: rtl/core/irsq_pkg.sv
// ----------------------------------------------------------------------------
// irsq_pkg
// types, codes and constants shared by the indexed random set queue
// ----------------------------------------------------------------------------
package irsq_pkg;

   // field widths of the request and response words
   localparam int CMD_W   = 2;
   localparam int IDX_W   = 8;
   localparam int RND_W   = 16;
   localparam int STAT_W  = 2;
   localparam int CNT_W   = 9;

   // number of distinct index codes the index field can carry
   localparam int IDX_SPACE = 2 ** IDX_W;

   // default number of slots
   localparam int SLOTS_DEFAULT = 256;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_ENQ   = 2'd0,
      CMD_DEL   = 2'd1,
      CMD_DEQ   = 2'd2,
      CMD_QUERY = 2'd3
   } cmd_type;

   // response status codes
   typedef enum logic [STAT_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_DUP    = 2'd1,
      STAT_ABSENT = 2'd2,
      STAT_EMPTY  = 2'd3
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_PICK,
      ST_COMMIT
   } state_type;

   // request word
   typedef struct packed {
      cmd_type            command;
      logic [IDX_W-1:0]   index;
      logic [RND_W-1:0]   random;
   } req_word_type;

   // response word
   typedef struct packed {
      logic [IDX_W-1:0]   picked_index;
      status_type         status;
      logic               present;
      logic [CNT_W-1:0]   member_count;
      logic               empty_res;
   } rsp_word_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic lookup;
      logic pick;
      logic commit;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_dequeue;
      logic out_busy;
   } dp_stat_type;

endpackage

// File: rtl/core/indexed_random_set_queue.sv
// ----------------------------------------------------------------------------
// indexed_random_set_queue
// set of distinct indices with append, swap-remove delete, random dequeue
// and membership query; one response word per request word
//
// request channel (req_valid, req_stall, req_word): a word is taken at a
// clock edge with req_valid high and req_stall low. response channel
// (rsp_valid, rsp_stall, rsp_word) hands the result the same way.
// after the accepting edge, enqueue, delete and query go through the lookup
// and commit states; dequeue adds a pick state, as it needs a second read of the
// member table (pick entry, then last entry) through its single read port.
// rsp_valid rises with the commit; req_stall stays high from accept to commit.
// the response sits in an output register; a new request is taken while it
// waits, and the commit step holds while the receiver stalls.
// reset clears the count and membership bits and holds req_stall high; the
// member and position tables need no clearing, so the block is ready the
// cycle after reset.
// ----------------------------------------------------------------------------
`include "indexed_random_set_queue_defines.svh"

module indexed_random_set_queue #(
   parameter int SLOTS = irsq_pkg::SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  irsq_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output irsq_pkg::rsp_word_type rsp_word
);

   import irsq_pkg::*;

   localparam int NUM_IDX = (SLOTS < IDX_SPACE) ? SLOTS : IDX_SPACE;

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;

   // sequencer
   irsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_stat   (dp_stat),
      .ctrl_cmd  (ctrl_cmd)
   );

   // tables and response register
   irsq_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .ctrl_cmd  (ctrl_cmd),
      .dp_stat   (dp_stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // checks
   `IRSQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `IRSQ_ASSERT_SAME(a_commit_free, clock, reset, ctrl_cmd.commit, !dp_stat.out_busy)
   `IRSQ_ASSERT_SAME(a_empty_flag, clock, reset, rsp_valid, rsp_word.empty_res == (rsp_word.member_count == '0))
   `IRSQ_ASSERT_SAME(a_count_bound, clock, reset, rsp_valid, rsp_word.member_count <= CNT_W'(NUM_IDX))

endmodule

// File: rtl/core/irsq_ram.sv
// ----------------------------------------------------------------------------
// irsq_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module irsq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/irsq_ctrl.sv
// ----------------------------------------------------------------------------
// irsq_ctrl
// command sequencer: accept, table lookup, optional pick read, commit
// ----------------------------------------------------------------------------
module irsq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  irsq_pkg::dp_stat_type  dp_stat,
   output irsq_pkg::ctrl_cmd_type ctrl_cmd
);

   import irsq_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = dp_stat.is_dequeue ? ST_PICK : ST_COMMIT;
         end
         ST_PICK: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!dp_stat.out_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs; no word is taken while reset is held
   always_comb begin
      req_stall       = 1'b1;
      ctrl_cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall     = reset;
            ctrl_cmd.load = req_valid && !reset;
         end
         ST_LOOKUP: begin
            ctrl_cmd.lookup = 1'b1;
         end
         ST_PICK: begin
            ctrl_cmd.pick = 1'b1;
         end
         ST_COMMIT: begin
            ctrl_cmd.commit = !dp_stat.out_busy;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// File: rtl/core/irsq_datapath.sv
// ----------------------------------------------------------------------------
// irsq_datapath
// member tables, membership bits, count and response register
// ----------------------------------------------------------------------------
module irsq_datapath #(
   parameter int SLOTS = irsq_pkg::SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  irsq_pkg::req_word_type req_word,
   input  irsq_pkg::ctrl_cmd_type ctrl_cmd,
   output irsq_pkg::dp_stat_type  dp_stat,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output irsq_pkg::rsp_word_type rsp_word
);

   import irsq_pkg::*;

   // usable index range and table address width
   localparam int NUM_IDX = (SLOTS < IDX_SPACE) ? SLOTS : IDX_SPACE;
   localparam int AW      = $clog2(NUM_IDX);
   localparam int PROD_W  = CNT_W + RND_W;

   // control state
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [NUM_IDX-1:0] valid_ff;
   logic               rsp_valid_ff;

   // captured command
   cmd_type            cmd_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [AW-1:0]      k_ff;
   logic [AW-1:0]      picked_ff;
   rsp_word_type       rsp_ff;
   rsp_word_type       rsp_in;

   // table ports
   logic               dense_we;
   logic [AW-1:0]      dense_waddr;
   logic [AW-1:0]      dense_wdata;
   logic [AW-1:0]      dense_raddr;
   logic [AW-1:0]      dense_rdata;
   logic               pos_we;
   logic [AW-1:0]      pos_waddr;
   logic [AW-1:0]      pos_wdata;
   logic [AW-1:0]      pos_rdata;

   // membership bit update
   logic               vld_we;
   logic [AW-1:0]      vld_addr;
   logic               vld_data;

   // derived values
   logic [PROD_W-1:0]  prod;
   logic [CNT_W-1:0]   k_full;
   logic [CNT_W-1:0]   cnt_dec;
   logic [AW-1:0]      idx_a;
   logic [AW-1:0]      last_a;
   logic               in_range;
   logic               was_member;

   assign idx_a      = idx_ff[AW-1:0];
   assign cnt_dec    = count_ff - CNT_W'(1);
   assign last_a     = cnt_dec[AW-1:0];
   assign in_range   = ({1'b0, idx_ff} < (IDX_W+1)'(NUM_IDX));
   assign was_member = in_range && valid_ff[idx_a];

   // dequeue position: floor(count * random / 65536)
   assign prod   = PROD_W'(count_ff) * PROD_W'(req_word.random);
   assign k_full = prod[RND_W +: CNT_W];

   // capture the accepted request word
   always_ff @(posedge clock) begin
      if (ctrl_cmd.load) begin
         cmd_ff <= req_word.command;
         idx_ff <= req_word.index;
         k_ff   <= k_full[AW-1:0];
      end
      if (ctrl_cmd.pick) begin
         picked_ff <= dense_rdata;
      end
      if (ctrl_cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   // read addresses: dequeue reads its pick first, everything else the last entry
   assign dense_raddr = (ctrl_cmd.lookup && (cmd_ff == CMD_DEQ)) ? k_ff : last_a;

   irsq_ram #(
      .WIDTH (AW),
      .DEPTH (NUM_IDX)
   ) u_dense (
      .clock   (clock),
      .wr_en   (dense_we),
      .wr_addr (dense_waddr),
      .wr_data (dense_wdata),
      .rd_addr (dense_raddr),
      .rd_data (dense_rdata)
   );

   irsq_ram #(
      .WIDTH (AW),
      .DEPTH (NUM_IDX)
   ) u_position (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (pos_waddr),
      .wr_data (pos_wdata),
      .rd_addr (idx_a),
      .rd_data (pos_rdata)
   );

   // commit decisions: table writes, count update and response word
   always_comb begin
      dense_we    = 1'b0;
      dense_waddr = dense_rdata;
      dense_wdata = dense_rdata;
      pos_we      = 1'b0;
      pos_waddr   = dense_rdata;
      pos_wdata   = pos_rdata;
      vld_we      = 1'b0;
      vld_addr    = idx_a;
      vld_data    = 1'b0;
      count_in    = count_ff;
      rsp_in      = '0;
      rsp_in.status  = STAT_OK;
      rsp_in.present = was_member;

      case (cmd_ff)
         CMD_ENQ: begin
            if (!in_range) begin
               rsp_in.status = STAT_ABSENT;
            end else if (was_member) begin
               rsp_in.status = STAT_DUP;
            end else if (count_ff < CNT_W'(NUM_IDX)) begin
               dense_we    = 1'b1;
               dense_waddr = count_ff[AW-1:0];
               dense_wdata = idx_a;
               pos_we      = 1'b1;
               pos_waddr   = idx_a;
               pos_wdata   = count_ff[AW-1:0];
               vld_we      = 1'b1;
               vld_data    = 1'b1;
               count_in    = count_ff + CNT_W'(1);
            end
         end
         CMD_DEL: begin
            if (!was_member) begin
               rsp_in.status = STAT_ABSENT;
            end else begin
               // last entry moves into the hole
               dense_we    = 1'b1;
               dense_waddr = pos_rdata;
               dense_wdata = dense_rdata;
               pos_we      = 1'b1;
               pos_waddr   = dense_rdata;
               pos_wdata   = pos_rdata;
               vld_we      = 1'b1;
               count_in    = cnt_dec;
            end
         end
         CMD_DEQ: begin
            if (count_ff == '0) begin
               rsp_in.status = STAT_EMPTY;
            end else begin
               dense_we    = 1'b1;
               dense_waddr = k_ff;
               dense_wdata = dense_rdata;
               pos_we      = 1'b1;
               pos_waddr   = dense_rdata;
               pos_wdata   = k_ff;
               vld_we      = 1'b1;
               vld_addr    = picked_ff;
               count_in    = cnt_dec;
               rsp_in.picked_index = IDX_W'(picked_ff);
            end
         end
         default: begin
            rsp_in.status = STAT_OK;
         end
      endcase

      rsp_in.member_count = count_in;
      rsp_in.empty_res    = (count_in == '0);

      // writes only land in the commit cycle
      if (!ctrl_cmd.commit) begin
         dense_we = 1'b0;
         pos_we   = 1'b0;
         vld_we   = 1'b0;
         count_in = count_ff;
      end
   end

   // count, membership bits and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (vld_we) begin
            valid_ff[vld_addr] <= vld_data;
         end
         if (ctrl_cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // status towards the controller
   assign dp_stat.is_dequeue = (cmd_ff == CMD_DEQ);
   assign dp_stat.out_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
